[hdl/spatial_sir_euler_step_unit_macros.svh]
// Assertion macros for the spatial SIR Euler step unit.
`ifndef SPATIAL_SIR_EULER_STEP_UNIT_MACROS_SVH
`define SPATIAL_SIR_EULER_STEP_UNIT_MACROS_SVH
`ifndef SYNTH
`define SSES_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SSES_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define SSES_ASSERT_IMPL(label, clk, rst, prop)
`define SSES_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[hdl/sses_pkg.sv]
// ----------------------------------------------------------------------------
// sses_pkg
// Types, constants and arithmetic helpers of the spatial SIR Euler step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sses_pkg;
   localparam int GRID_DIM_DEFAULT = 64;
   localparam int CELL_W = 12;
   localparam int NUM_REGS = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [2:0] REG_BETA_MEAN = 3'd0;
   localparam logic [2:0] REG_COUPLING  = 3'd1;
   localparam logic [2:0] REG_RECOVERY  = 3'd2;
   localparam logic [2:0] REG_COOLING   = 3'd3;
   localparam logic [2:0] REG_SHOCK     = 3'd4;
   localparam logic [2:0] REG_STEP      = 3'd5;

   localparam logic [30:0] RST_BETA_MEAN = 31'd1288490;
   localparam logic [30:0] RST_COUPLING  = 31'd10737418;
   localparam logic [30:0] RST_RECOVERY  = 31'd214748365;
   localparam logic [30:0] RST_COOLING   = 31'd536870912;
   localparam logic [30:0] RST_SHOCK     = 31'd1073742;
   localparam logic [30:0] RST_STEP      = 31'd107374182;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [11:0] cell_index;
      logic        sweep_start;
      logic signed [15:0] noise_sample;
      logic [30:0] load_susceptible;
      logic [30:0] load_infected;
      logic [30:0] load_recovered;
   } req_type;

   typedef struct packed {
      logic [11:0] out_cell;
      logic signed [31:0] susceptible_out;
      logic signed [31:0] infected_out;
      logic signed [31:0] recovered_out;
      logic signed [31:0] rate_out;
      logic [3:0]  neighbour_total;
   } rsp_type;

   typedef struct packed {
      logic [30:0] beta_mean;
      logic [30:0] coupling;
      logic [30:0] recovery;
      logic [30:0] cooling;
      logic [30:0] shock;
      logic [30:0] step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_SELF, ST_RD_NB, ST_DRAIN, ST_MATH, ST_WRITE, ST_OUT
   } state_type;

   // Saturate a 66 bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Round to nearest (ties up) and saturate a 64 bit product shifted by s + 1.
   function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p,
                                                   input int s);
      logic signed [65:0] w;
      w = ($signed({{2{p[63]}}, p}) + (66'sd1 <<< s)) >>> (s + 1);
      return sat32(w);
   endfunction
endpackage

[hdl/sses_ram.sv]
// ----------------------------------------------------------------------------
// sses_ram
// Generic single port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sses_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Registered read; a read during a write returns the old entry.
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[hdl/sses_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sses_cfg_regs
// Configuration register file of the spatial SIR Euler step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sses_cfg_regs import sses_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);
   cfg_type cfg_ff;

   // Registers written by index; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RST_BETA_MEAN, RST_COUPLING, RST_RECOVERY, RST_COOLING,
                     RST_SHOCK, RST_STEP};
      end else if (csr_write) begin
         case (csr_index)
            REG_BETA_MEAN: cfg_ff.beta_mean <= csr_data;
            REG_COUPLING:  cfg_ff.coupling  <= csr_data;
            REG_RECOVERY:  cfg_ff.recovery  <= csr_data;
            REG_COOLING:   cfg_ff.cooling   <= csr_data;
            REG_SHOCK:     cfg_ff.shock     <= csr_data;
            REG_STEP:      cfg_ff.step      <= csr_data;
            default: ;
         endcase
      end
   end
   assign cfg = cfg_ff;
endmodule

[hdl/sses_math.sv]
// ----------------------------------------------------------------------------
// sses_math
// Shared multiplier sequencer: one 32x32 product per cycle through the Euler
// step dependency chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sses_math import sses_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cfg_type            cfg,
   input  logic signed [15:0] noise,
   input  logic signed [31:0] rate_self,
   input  logic signed [31:0] s_val,
   input  logic signed [31:0] i_val,
   input  logic signed [31:0] r_val,
   input  logic signed [31:0] pressure,
   input  logic [3:0]         n_count,
   output logic               done,
   output logic signed [31:0] s_new,
   output logic signed [31:0] i_new,
   output logic signed [31:0] r_new,
   output logic signed [31:0] rate_new
);
   logic [3:0] step_ff, step_in;
   logic busy_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, rate_ff, ds_ff, ri_ff;
   logic signed [31:0] s1_ff, i1_ff, r1_ff;
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic [5:0] sh;
   logic signed [31:0] mres;
   logic signed [31:0] bm, alpha, coeff;

   assign bm = $signed({1'b0, cfg.beta_mean});
   assign alpha = $signed({1'b0, cfg.coupling});
   assign coeff = sat32(66'sd1073741824 - $signed({62'd0, n_count}) * alpha);

   // Operand selection per step of the chain.
   always_comb begin
      ma = '0; mb = '0; sh = 6'd30;
      case (step_ff)
         4'd0: begin ma = $signed({1'b0, cfg.cooling}); mb = sat32(rate_self - bm); end
         4'd1: begin ma = $signed({1'b0, cfg.shock}); mb = 32'(noise); sh = 6'd12; end
         4'd2: begin ma = rate_ff; mb = s_val; end
         4'd3: begin ma = a_ff; mb = i_val; sh = 6'd16; end
         4'd4: begin ma = coeff; mb = a_ff; end
         4'd5: begin ma = alpha; mb = s_val; end
         4'd6: begin ma = c_ff; mb = pressure; sh = 6'd16; end
         4'd7: begin ma = $signed({1'b0, cfg.recovery}); mb = i_val; end
         4'd8: begin ma = $signed({1'b0, cfg.step}); mb = ds_ff; end
         4'd9: begin ma = $signed({1'b0, cfg.step}); mb = d_ff; end
         4'd10: begin ma = $signed({1'b0, cfg.step}); mb = ri_ff; end
         default: ;
      endcase
      prod = ma * mb;
      mres = rnd_sat(prod, int'(sh) - 1);
   end

   assign step_in = busy_ff ? step_ff + 4'd1 : 4'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (start) busy_ff <= 1'b1;
         else if (step_ff == 4'd10) busy_ff <= 1'b0;
         step_ff <= step_in;
      end
   end

   // Result registers along the chain.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         case (step_ff)
            4'd0: e_ff <= mres;
            4'd1: rate_ff <= sat32(66'(bm) + 66'(e_ff) + 66'(mres));
            4'd2: a_ff <= mres;
            4'd3: a_ff <= mres;
            4'd4: b_ff <= mres;
            4'd5: c_ff <= mres;
            4'd6: ds_ff <= sat32(-66'(b_ff) - 66'(mres));
            4'd7: begin
               ri_ff <= mres;
               d_ff <= sat32(-66'(ds_ff) - 66'(mres));
            end
            4'd8: s1_ff <= sat32(66'(s_val) + 66'(mres));
            4'd9: i1_ff <= sat32(66'(i_val) + 66'(mres));
            4'd10: r1_ff <= sat32(66'(r_val) + 66'(mres));
            default: ;
         endcase
      end
   end

   assign done = busy_ff && step_ff == 4'd10;
   assign s_new = s1_ff;
   assign i_new = i1_ff;
   assign r_new = r1_ff;
   assign rate_new = rate_ff;
endmodule

[hdl/spatial_sir_euler_step_unit.sv]
// ----------------------------------------------------------------------------
// Spatial SIR Euler step unit. A load writes at its self read and goes to output; an
// update runs self read, eight neighbour reads, drain, eleven products on one multiplier,
// write back, output. The next beat is taken in the cycle after the result beat leaves.
// Synchronous reset clears control, configuration and bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spatial_sir_euler_step_unit_macros.svh"
module spatial_sir_euler_step_unit import sses_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int CELLS = GRID_DIM * GRID_DIM;
   localparam int AW = $clog2(CELLS);
   localparam int DIM_W = $clog2(GRID_DIM);
   localparam int RECIP_SH = AW + DIM_W;
   localparam logic [63:0] RECIP =
      ((64'd1 << RECIP_SH) + 64'(GRID_DIM) - 64'd1) / 64'(GRID_DIM);

   cfg_type cfg;
   sses_cfg_regs u_cfg (.clock, .reset, .csr_write, .csr_index, .csr_data, .cfg);

   state_type state_ff, state_in;
   req_type req_ff;
   logic bank_ff;
   logic [3:0] nb_ff;          // neighbour position being issued 0..7
   logic [3:0] cnt_ff;
   logic nb_vld_ff;            // the outstanding read is of an in-grid neighbour
   logic signed [31:0] s_ff, i_ff, r_ff, rt_ff, p_ff;
   logic signed [65:0] psum_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   // Memory ports: one memory for S, R and rate, one for both infected banks.
   logic [AW-1:0] addr;
   logic we, inf_we;
   logic [95:0] srr_rd;
   logic [63:0] inf_rd;
   logic [31:0] s_rd, r_rd, rt_rd, i0_rd, i1_rd;
   logic [31:0] s_wd, r_wd, rt_wd, i0_wd, i1_wd;

   sses_ram #(.WIDTH(96), .DEPTH(CELLS)) u_srr (.clock, .wr_en(we), .addr,
      .wr_data({rt_wd, r_wd, s_wd}), .rd_data(srr_rd));
   sses_ram #(.WIDTH(64), .DEPTH(CELLS)) u_inf (.clock, .wr_en(inf_we), .addr,
      .wr_data({i1_wd, i0_wd}), .rd_data(inf_rd));
   assign {rt_rd, r_rd, s_rd} = srr_rd;
   assign {i1_rd, i0_rd} = inf_rd;

   // Row and column of the held cell index by reciprocal multiplication.
   logic [AW-1:0] cell_addr;
   logic [63:0] row_prod;
   logic [AW-1:0] row_in, col_in, row_ff, col_ff;
   assign cell_addr = AW'(req_ff.cell_index);
   assign row_prod = 64'(cell_addr) * RECIP;
   assign row_in = AW'(row_prod >> RECIP_SH);
   assign col_in = cell_addr - AW'(row_in * GRID_DIM);

   // Neighbour geometry: offsets of the eight positions around the cell.
   logic [1:0] kr, kc;
   logic signed [AW+1:0] nr, nc;
   logic nb_in;
   always_comb begin
      kr = 2'd0; kc = 2'd0;
      case (nb_ff)
         4'd0: begin kr = 2'd0; kc = 2'd0; end
         4'd1: begin kr = 2'd0; kc = 2'd1; end
         4'd2: begin kr = 2'd0; kc = 2'd2; end
         4'd3: begin kr = 2'd1; kc = 2'd0; end
         4'd4: begin kr = 2'd1; kc = 2'd2; end
         4'd5: begin kr = 2'd2; kc = 2'd0; end
         4'd6: begin kr = 2'd2; kc = 2'd1; end
         4'd7: begin kr = 2'd2; kc = 2'd2; end
         default: ;
      endcase
      nr = $signed({2'b00, row_ff}) + $signed({{AW{1'b0}}, kr}) - (AW+2)'(1);
      nc = $signed({2'b00, col_ff}) + $signed({{AW{1'b0}}, kc}) - (AW+2)'(1);
      nb_in = nr >= 0 && nr < GRID_DIM && nc >= 0 && nc < GRID_DIM;
   end

   logic m_start, m_done;
   logic signed [31:0] ms, mi, mr, mrate;
   sses_math u_math (.clock, .reset, .start(m_start), .cfg,
      .noise(req_ff.noise_sample), .rate_self(rt_ff), .s_val(s_ff), .i_val(i_ff),
      .r_val(r_ff), .pressure(p_ff), .n_count(cnt_ff), .done(m_done),
      .s_new(ms), .i_new(mi), .r_new(mr), .rate_new(mrate));

   logic in_grid;
   assign in_grid = 32'(req_data.cell_index) < CELLS;
   assign req_stall = state_ff != ST_IDLE || rsp_valid_ff;

   logic signed [31:0] i_rd;
   assign i_rd = bank_ff ? $signed(i1_rd) : $signed(i0_rd);
   logic signed [31:0] i1_hold;

   // Next state and memory control.
   always_comb begin
      state_in = state_ff;
      addr = cell_addr;
      we = 1'b0; inf_we = 1'b0;
      s_wd = {1'b0, req_ff.load_susceptible};
      r_wd = {1'b0, req_ff.load_recovered};
      rt_wd = {1'b0, cfg.beta_mean};
      i0_wd = {1'b0, req_ff.load_infected};
      i1_wd = {1'b0, req_ff.load_infected};
      m_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall && in_grid) state_in = ST_RD_SELF;
         end
         ST_RD_SELF: begin
            if (req_ff.command == CMD_LOAD) begin
               we = 1'b1; inf_we = 1'b1;
               state_in = ST_OUT;
            end else state_in = ST_RD_NB;
         end
         ST_RD_NB: begin
            addr = AW'(nr * GRID_DIM + nc);
            if (nb_ff == 4'd7) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            m_start = 1'b1;
            state_in = ST_MATH;
         end
         ST_MATH: if (m_done) state_in = ST_WRITE;
         ST_WRITE: begin
            // The read bank keeps its entry; the other bank takes the new count.
            we = 1'b1; inf_we = 1'b1;
            s_wd = ms; r_wd = mr; rt_wd = mrate;
            i0_wd = bank_ff ? mi : i_ff;
            i1_wd = bank_ff ? i_ff : mi;
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bank_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && req_valid && !req_stall && in_grid &&
             req_data.command == CMD_UPDATE && req_data.sweep_start)
            bank_ff <= !bank_ff;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) req_ff <= req_data;
      if (state_ff == ST_RD_SELF) begin
         nb_ff <= '0; cnt_ff <= '0; psum_ff <= '0; nb_vld_ff <= 1'b0;
         row_ff <= row_in; col_ff <= col_in;
      end
      if (state_ff == ST_RD_NB) begin
         nb_ff <= nb_ff + 4'd1;
         nb_vld_ff <= nb_in;
         if (nb_in) cnt_ff <= cnt_ff + 4'd1;
      end
      // Self entry arrives in the cycle after the self read.
      if (state_ff == ST_RD_NB && nb_ff == 4'd0) begin
         s_ff <= s_rd; r_ff <= r_rd; rt_ff <= rt_rd; i_ff <= i_rd;
      end
      if ((state_ff == ST_RD_NB && nb_ff != 4'd0) || state_ff == ST_DRAIN) begin
         if (nb_vld_ff) psum_ff <= psum_ff + 66'(rnd_sat($signed(rt_rd) * i_rd, 29));
      end
      if (state_ff == ST_DRAIN) p_ff <= sat32(psum_ff + (nb_vld_ff ?
            66'(rnd_sat($signed(rt_rd) * i_rd, 29)) : 66'sd0));
      if (state_ff == ST_OUT) begin
         if (req_ff.command == CMD_LOAD) begin
            rsp_ff <= '{req_ff.cell_index, {1'b0, req_ff.load_susceptible},
                        {1'b0, req_ff.load_infected}, {1'b0, req_ff.load_recovered},
                        {1'b0, cfg.beta_mean}, 4'd0};
         end else begin
            rsp_ff <= '{req_ff.cell_index, s_ff, i1_hold, r_ff, rt_ff, cnt_ff};
         end
      end
      if (state_ff == ST_WRITE) begin
         s_ff <= ms; rt_ff <= mrate; r_ff <= mr; i1_hold <= mi;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `SSES_ASSERT_NEVER(a_no_accept_busy, clock, reset, req_valid && !req_stall && state_ff != ST_IDLE)
   `SSES_ASSERT_IMPL(a_out_valid, clock, reset, state_ff == ST_OUT |=> rsp_valid)
   `SSES_ASSERT_IMPL(a_math_done, clock, reset, m_done |=> state_ff == ST_WRITE)
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spatial SIR Euler step unit. A queue of request
// beats feeds a bursty driver. Each accepted beat runs through a local model
// of the grid state that predicts its result. A monitor behind a randomly
// stalling receiver compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   import sses_pkg::*;

   localparam int DIM = GRID_DIM_DEFAULT;
   localparam int CELLS = DIM * DIM;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [2:0] REG_PAST_END = 3'(NUM_REGS);
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic [30:0] MAX31 = 31'h7fffffff;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus and expectation stores.
   req_type pending_beats[$];
   rsp_type expected_cells[$];
   int errors = 0;

   // Local copy of the grid state and registers.
   logic [30:0] reg_val[NUM_REGS];
   longint sus_mem[CELLS];
   longint rec_mem[CELLS];
   longint rate_mem[CELLS];
   longint inf_mem[2][CELLS];
   bit bank;

   // Generation-side bookkeeping: which cells are loaded and safe to update.
   bit loaded[CELLS];
   bit updatable[CELLS];
   int updatable_list[$];

   spatial_sir_euler_step_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Fixed-point product, rounded half up at the result format, saturated.
   function automatic longint fx_mul(longint a, longint b, int s);
      longint p;
      p = a * b + (longint'(1) <<< (s - 1));
      return clamp32(p >>> s);
   endfunction

   // One Euler step or load of a cell; updates the local grid state.
   function automatic rsp_type sir_step(req_type q);
      rsp_type o;
      int c, row, col, nr, nc, idx, n, rb;
      longint beta, alpha, rr, eta, shock, h, press, dev, rate;
      longint s_v, i_v, r_v, coeff, bs, bsi, t1, as_v, t2, d_s, r_i, d_i;
      beta = reg_val[REG_BETA_MEAN];
      alpha = reg_val[REG_COUPLING];
      rr = reg_val[REG_RECOVERY];
      eta = reg_val[REG_COOLING];
      shock = reg_val[REG_SHOCK];
      h = reg_val[REG_STEP];
      c = q.cell_index;
      o.out_cell = q.cell_index;
      if (q.command == CMD_LOAD) begin
         sus_mem[c] = q.load_susceptible;
         inf_mem[0][c] = q.load_infected;
         inf_mem[1][c] = q.load_infected;
         rec_mem[c] = q.load_recovered;
         rate_mem[c] = beta;
         o.susceptible_out = {1'b0, q.load_susceptible};
         o.infected_out = {1'b0, q.load_infected};
         o.recovered_out = {1'b0, q.load_recovered};
         o.rate_out = {1'b0, reg_val[REG_BETA_MEAN]};
         o.neighbour_total = '0;
         return o;
      end
      if (q.sweep_start) bank = ~bank;
      rb = bank;
      row = c / DIM;
      col = c % DIM;
      n = 0;
      press = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            nr = row + dr;
            nc = col + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nr < DIM && nc >= 0 && nc < DIM) begin
               idx = nr * DIM + nc;
               press += fx_mul(rate_mem[idx], inf_mem[rb][idx], 30);
               n++;
            end
         end
      end
      press = clamp32(press);
      dev = clamp32(rate_mem[c] - beta);
      rate = clamp32(beta + fx_mul(eta, dev, 30)
                     + fx_mul(shock, longint'($signed(q.noise_sample)), 12));
      s_v = sus_mem[c];
      i_v = inf_mem[rb][c];
      r_v = rec_mem[c];
      coeff = clamp32((longint'(1) <<< 30) - longint'(n) * alpha);
      bs = fx_mul(rate, s_v, 30);
      bsi = fx_mul(bs, i_v, 16);
      t1 = fx_mul(coeff, bsi, 30);
      as_v = fx_mul(alpha, s_v, 30);
      t2 = fx_mul(as_v, press, 16);
      d_s = clamp32(-t1 - t2);
      r_i = fx_mul(rr, i_v, 30);
      d_i = clamp32(-d_s - r_i);
      sus_mem[c] = clamp32(s_v + fx_mul(h, d_s, 30));
      inf_mem[rb ^ 1][c] = clamp32(i_v + fx_mul(h, d_i, 30));
      rec_mem[c] = clamp32(r_v + fx_mul(h, r_i, 30));
      rate_mem[c] = rate;
      o.susceptible_out = sus_mem[c][31:0];
      o.infected_out = inf_mem[rb ^ 1][c][31:0];
      o.recovered_out = rec_mem[c][31:0];
      o.rate_out = rate[31:0];
      o.neighbour_total = n[3:0];
      return o;
   endfunction

   // A cell may be updated once it and all its in-grid neighbours are loaded.
   function automatic bit area_loaded(int c);
      int nr, nc;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            nr = c / DIM + dr;
            nc = c % DIM + dc;
            if (nr >= 0 && nr < DIM && nc >= 0 && nc < DIM && !loaded[nr * DIM + nc])
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [30:0] rand_count();
      case ($urandom_range(0, 4))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 1 << 20));
         2: return 31'($urandom_range(0, 1 << 24));
         3: return 31'($urandom_range(0, 1 << 27));
         default: return ($urandom_range(0, 1) != 0) ? MAX31 : 31'd0;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_noise();
      if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 16383) - 8192);
      return 16'($urandom);
   endfunction

   // Queue one request beat and keep the loaded map current.
   task automatic push_beat(logic cmd, int c, logic sweep, logic signed [15:0] noise,
                            logic [30:0] s_v, logic [30:0] i_v, logic [30:0] r_v);
      req_type q;
      int nr, nc, idx;
      q.command = cmd;
      q.cell_index = c[11:0];
      q.sweep_start = sweep;
      q.noise_sample = noise;
      q.load_susceptible = s_v;
      q.load_infected = i_v;
      q.load_recovered = r_v;
      pending_beats.push_back(q);
      if (cmd == CMD_LOAD) begin
         loaded[c] = 1'b1;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               nr = c / DIM + dr;
               nc = c % DIM + dc;
               idx = nr * DIM + nc;
               if (nr >= 0 && nr < DIM && nc >= 0 && nc < DIM && !updatable[idx]
                   && area_loaded(idx)) begin
                  updatable[idx] = 1'b1;
                  updatable_list.push_back(idx);
               end
            end
         end
      end
   endtask

   task automatic push_update(int c, logic sweep, logic signed [15:0] noise);
      push_beat(CMD_UPDATE, c, sweep, noise, 31'($urandom), 31'($urandom), 31'($urandom));
   endtask

   task automatic push_load(int c, logic [30:0] s_v, logic [30:0] i_v, logic [30:0] r_v);
      push_beat(CMD_LOAD, c, 1'($urandom_range(0, 1)), 16'($urandom), s_v, i_v, r_v);
   endtask

   // Load a random block of cells, then run updates, with occasional reloads, over ready cells.
   task automatic random_block(inout int budget);
      int r0, c0, hgt, wid, k, c;
      hgt = $urandom_range(2, 4);
      wid = $urandom_range(2, 4);
      r0 = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : DIM - hgt)
                                       : $urandom_range(0, DIM - hgt);
      c0 = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : DIM - wid)
                                       : $urandom_range(0, DIM - wid);
      for (int r = r0; r < r0 + hgt; r++) begin
         for (int cc = c0; cc < c0 + wid; cc++) begin
            push_load(r * DIM + cc, rand_count(), rand_count(), rand_count());
            budget--;
         end
      end
      k = $urandom_range(4, 16);
      for (int j = 0; j < k; j++) begin
         c = (r0 + $urandom_range(0, hgt - 1)) * DIM + c0 + $urandom_range(0, wid - 1);
         if (!updatable[c]) c = updatable_list[$urandom_range(0, updatable_list.size() - 1)];
         if ($urandom_range(0, 9) == 0)
            push_load(c, rand_count(), rand_count(), rand_count());
         else
            push_update(c, $urandom_range(0, 3) == 0, rand_noise());
         budget--;
      end
   endtask

   // Register write at one clock edge; only called while the unit is idle.
   task automatic write_reg(logic [2:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx < NUM_REGS) reg_val[idx] = value;
   endtask

   task automatic write_all(logic [30:0] v0, logic [30:0] v1, logic [30:0] v2,
                            logic [30:0] v3, logic [30:0] v4, logic [30:0] v5);
      write_reg(REG_BETA_MEAN, v0);
      write_reg(REG_COUPLING, v1);
      write_reg(REG_RECOVERY, v2);
      write_reg(REG_COOLING, v3);
      write_reg(REG_SHOCK, v4);
      write_reg(REG_STEP, v5);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || expected_cells.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: bursts of beats separated by random gaps.
   logic req_fire = 1'b0;
   int burst_left = 8;
   int gap_left = 0;
   always @(posedge clock) req_fire <= req_valid && !req_stall;

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: each random run uses one of four stall densities.
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(10, 60);
         stall_mode = $urandom_range(0, 3);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Prediction on each accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) expected_cells.push_back(sir_step(req_data));
   end

   // Result check against the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_cells.pop_front();
            if (e.out_cell !== rsp_data.out_cell) begin
               $display("%0t: out_cell exp %0d got %0d", $time, e.out_cell, rsp_data.out_cell);
               errors++;
            end
            if (e.susceptible_out !== rsp_data.susceptible_out) begin
               $display("%0t: susceptible_out exp %0d got %0d", $time,
                        e.susceptible_out, rsp_data.susceptible_out);
               errors++;
            end
            if (e.infected_out !== rsp_data.infected_out) begin
               $display("%0t: infected_out exp %0d got %0d", $time,
                        e.infected_out, rsp_data.infected_out);
               errors++;
            end
            if (e.recovered_out !== rsp_data.recovered_out) begin
               $display("%0t: recovered_out exp %0d got %0d", $time,
                        e.recovered_out, rsp_data.recovered_out);
               errors++;
            end
            if (e.rate_out !== rsp_data.rate_out) begin
               $display("%0t: rate_out exp %0d got %0d", $time, e.rate_out, rsp_data.rate_out);
               errors++;
            end
            if (e.neighbour_total !== rsp_data.neighbour_total) begin
               $display("%0t: neighbour_total exp %0d got %0d", $time,
                        e.neighbour_total, rsp_data.neighbour_total);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with work outstanding but no beat accepted.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (pending_beats.size() == 0 && expected_cells.size() == 0 && !req_valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed beats, then random phases per setting.
   initial begin
      int budget;
      reg_val[REG_BETA_MEAN] = RST_BETA_MEAN;
      reg_val[REG_COUPLING] = RST_COUPLING;
      reg_val[REG_RECOVERY] = RST_RECOVERY;
      reg_val[REG_COOLING] = RST_COOLING;
      reg_val[REG_SHOCK] = RST_SHOCK;
      reg_val[REG_STEP] = RST_STEP;
      bank = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Top-left corner with extreme counts and extreme noise.
      push_load(0, MAX31, 31'd0, 31'd0);
      push_load(1, 31'd0, MAX31, MAX31);
      push_load(64, 31'd65536 * 1000, 31'd65536 * 10, 31'd0);
      push_load(65, 31'd65536 * 500, 31'd65536 * 50, 31'd65536);
      push_update(0, 1'b1, 16'sh7fff);
      push_update(0, 1'b0, -16'sh8000);
      push_update(0, 1'b1, 16'sh0000);
      // Remaining corners: no wrap at the grid edges.
      push_load(62, 31'd65536 * 900, 31'd65536 * 3, 31'd0);
      push_load(63, 31'd65536 * 800, 31'd65536 * 7, 31'd100);
      push_load(126, 31'd65536 * 700, 31'd0, 31'd0);
      push_load(127, 31'd65536 * 600, 31'd65536 * 20, 31'd0);
      push_update(63, 1'b0, 16'sh1000);
      push_load(4030, rand_count(), rand_count(), rand_count());
      push_load(4031, rand_count(), rand_count(), rand_count());
      push_load(4094, rand_count(), rand_count(), rand_count());
      push_load(4095, rand_count(), rand_count(), rand_count());
      push_update(4095, 1'b1, -16'sh1000);
      push_load(3968, rand_count(), rand_count(), rand_count());
      push_load(3969, rand_count(), rand_count(), rand_count());
      push_load(4032, rand_count(), rand_count(), rand_count());
      push_load(4033, rand_count(), rand_count(), rand_count());
      push_update(4032, 1'b0, 16'sh0800);
      // Top edge cell with five neighbours.
      push_load(2, 31'd65536 * 300, 31'd65536 * 30, 31'd0);
      push_load(66, 31'd65536 * 200, 31'd65536 * 40, 31'd0);
      push_update(1, 1'b1, 16'sh0400);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: ;
            1: write_all(31'($urandom_range(0, 1 << 28)), 31'($urandom_range(0, 1 << 25)),
                         31'($urandom_range(0, 1 << 29)), 31'($urandom_range(0, 1 << 30)),
                         31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 29)));
            2: write_all(MAX31, MAX31, MAX31, MAX31, MAX31, MAX31);
            3: write_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
            4: begin
               write_all(RST_BETA_MEAN, RST_COUPLING, RST_RECOVERY, RST_COOLING,
                         RST_SHOCK, RST_STEP);
               write_reg(REG_UNUSED, MAX31);
               write_reg(REG_PAST_END, 31'h2aaaaaaa);
            end
            default: write_all(31'($urandom), 31'($urandom), 31'($urandom),
                               31'($urandom), 31'($urandom), 31'($urandom));
         endcase
         budget = 180;
         while (budget > 0) random_block(budget);
      end

      wait_idle();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[spatial_sir_euler_step_unit.f]
+incdir+hdl
hdl/sses_pkg.sv
hdl/sses_ram.sv
hdl/sses_cfg_regs.sv
hdl/sses_math.sv
hdl/spatial_sir_euler_step_unit.sv
dv/tb.sv
